// File: rtl/core/hhte_pkg.sv
package hhte_pkg;

  localparam int PLY_LIMIT_DEF = 64;
  localparam int SCORE_W = 16;
  localparam int MOVE_W = 32;
  localparam int BF_AW = 13;
  localparam int CTX_AW = 19;
  localparam int CTX_DEPTH = 294912;
  localparam int REPLY_AW = 10;
  localparam int REPLY_DEPTH = 768;
  localparam int BF_DEPTH = 8192;
  localparam logic [2:0] NO_PIECE = 3'd6;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_QUIET   = 3'd1,
    ACT_CAPTURE = 3'd2,
    ACT_PENALTY = 3'd3,
    ACT_QUERY   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [31:0] move_code;
    logic side;
    logic [2:0] piece_kind;
    logic [5:0] from_square;
    logic [5:0] to_square;
    logic [6:0] search_depth;
    logic [6:0] search_ply;
    logic [2:0] last_piece;
    logic [5:0] last_to;
    logic [2:0] earlier_piece;
    logic [5:0] earlier_to;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] combined_score;
    logic [31:0] killer_first;
    logic [31:0] killer_second;
    logic [31:0] counter_move;
  } out_word_t;

  // Gravity step after the product and the decay quotient are known.
  function automatic logic signed [15:0] grav_sat(input logic signed [15:0] s,
                                                  input logic [13:0] b,
                                                  input logic signed [15:0] decay,
                                                  input logic reward);
    logic signed [18:0] nv;
    begin
      nv = 19'(s) + (reward ? $signed({5'd0, b}) : -$signed({5'd0, b})) - 19'(decay);
      if (nv > 19'sd32767) grav_sat = 16'sh7fff;
      else if (nv < -19'sd32768) grav_sat = 16'sh8000;
      else grav_sat = nv[15:0];
    end
  endfunction

endpackage

// File: rtl/core/hhte_if.sv
interface hhte_in_if;
  logic valid;
  logic ready;
  hhte_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hhte_out_if;
  logic valid;
  logic ready;
  hhte_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hhte_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/history_heuristic_table_engine_top.sv
// Channel  Direction  Payload
// in       sink       in_word_t, one action per word
// out      source     out_word_t, one word per query
// cfg      sink       context_tables_enable
// A new word is accepted only in the idle state, after the previous word is done; a reward
// or penalty updates each enabled score table in turn, and a query reads all three tables.
// After reset and after a clear action the block sweeps all 294912 context
// entries, one per cycle, zeroing killers and replies in the same sweep.
// A query result waits in the output register; a later query waits in its last
// state until that register is free.
module history_heuristic_table_engine_top #(
  parameter int PLY_LIMIT = hhte_pkg::PLY_LIMIT_DEF
) (
  input logic clk,
  input logic rst,
  hhte_in_if.sink in,
  hhte_out_if.source out,
  hhte_cfg_if.sink cfg
);
  import hhte_pkg::*;

  localparam int PLY_AW = (PLY_LIMIT > 1) ? $clog2(PLY_LIMIT) : 1;

  state_t state, state_next;
  in_word_t cur;
  logic ctx_en;
  logic skip;
  logic [CTX_AW-1:0] clr_addr;
  logic [1:0] tsel;
  logic signed [17:0] acc;

  logic [BF_AW-1:0] bf_a;
  logic [CTX_AW-1:0] cm_a, fu_a;
  logic [REPLY_AW-1:0] rp_a;
  logic [15:0] bf_q, cm_q, fu_q;
  logic bf_we, cm_we, fu_we;
  logic [15:0] wval;
  logic [2:0] pk;
  logic lp_ok, ep_ok, ply_ok, upd;
  logic [31:0] k0 [PLY_LIMIT];
  logic [31:0] k1 [PLY_LIMIT];
  logic [31:0] k0_q, k1_q;
  logic [31:0] reply [REPLY_DEPTH];
  logic [31:0] rp_q;
  logic g_start, g_done;
  logic signed [15:0] g_res, g_in;
  logic [PLY_AW-1:0] ply_i;
  logic out_vld, out_load;
  out_word_t res_word;

  assign pk = (cur.piece_kind > 3'd5) ? 3'd5 : cur.piece_kind;
  assign lp_ok = cur.last_piece < NO_PIECE;
  assign ep_ok = cur.earlier_piece < NO_PIECE;
  assign ply_ok = 8'(cur.search_ply) < 8'(PLY_LIMIT);
  assign ply_i = PLY_AW'(cur.search_ply);
  assign bf_a = {cur.side, cur.from_square, cur.to_square};
  assign cm_a = (state == ST_CLEAR) ? clr_addr :
    CTX_AW'((((19'(cur.side) * 19'd6 + 19'(cur.last_piece)) * 19'd64
      + 19'(cur.last_to)) * 19'd6 + 19'(pk)) * 19'd64 + 19'(cur.to_square));
  assign fu_a = (state == ST_CLEAR) ? clr_addr :
    CTX_AW'((((19'(cur.side) * 19'd6 + 19'(cur.earlier_piece)) * 19'd64
      + 19'(cur.earlier_to)) * 19'd6 + 19'(pk)) * 19'd64 + 19'(cur.to_square));
  assign rp_a = REPLY_AW'(({~cur.side} * 10'd6 + 10'(cur.last_piece)) * 10'd64
    + 10'(cur.last_to));

  hhte_score_ram #(.DEPTH(BF_DEPTH), .AW(BF_AW)) u_bf (
    .clk, .we(bf_we), .waddr(state == ST_CLEAR ? clr_addr[BF_AW-1:0] : bf_a),
    .wdata(wval), .raddr(bf_a), .rdata(bf_q));
  hhte_score_ram #(.DEPTH(CTX_DEPTH), .AW(CTX_AW)) u_cm (
    .clk, .we(cm_we), .waddr(cm_a), .wdata(wval), .raddr(cm_a), .rdata(cm_q));
  hhte_score_ram #(.DEPTH(CTX_DEPTH), .AW(CTX_AW)) u_fu (
    .clk, .we(fu_we), .waddr(fu_a), .wdata(wval), .raddr(fu_a), .rdata(fu_q));

  assign g_in = (tsel == 2'd0) ? $signed(bf_q) : (tsel == 2'd1) ? $signed(cm_q) : $signed(fu_q);

  hhte_gravity u_grav (
    .clk, .rst, .start(g_start), .score(g_in), .depth(cur.search_depth),
    .reward(cur.action == ACT_QUIET), .done(g_done), .result(g_res));

  assign upd = cur.search_depth > 7'd2 &&
    (cur.action == ACT_QUIET || (cur.action == ACT_PENALTY && !skip));

  function automatic logic tbl_on(input logic [1:0] t, input logic c, input logic l,
                                  input logic e);
    tbl_on = (t == 2'd0) || (t == 2'd1 && c && l) || (t == 2'd2 && c && e);
  endfunction

  logic rd_wait;
  always_ff @(posedge clk) begin
    if (rst) rd_wait <= 1'b0;
    else rd_wait <= (state == ST_READ) && !rd_wait;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in.valid) state_next = (in.data.action == ACT_CLEAR) ? ST_CLEAR : ST_READ;
      ST_CLEAR: if (clr_addr == CTX_AW'(CTX_DEPTH - 1)) state_next = ST_IDLE;
      ST_READ: begin
        if (rd_wait) begin
          if (cur.action == ACT_QUERY) state_next = (tsel == 2'd2) ? ST_OUT : ST_READ;
          else if (!upd) state_next = ST_WRITE;
          else if (tbl_on(tsel, ctx_en, lp_ok, ep_ok)) state_next = ST_MUL;
          else state_next = (tsel == 2'd2) ? ST_WRITE : ST_READ;
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: if (g_done) state_next = (tsel == 2'd2) ? ST_WRITE : ST_READ;
      ST_WRITE: state_next = ST_IDLE;
      ST_OUT: if (!out_vld || out.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in.ready = (state == ST_IDLE);
    cfg.ready = (state == ST_IDLE);
    out.valid = out_vld;
    out_load = (state == ST_OUT) && (!out_vld || out.ready);
    g_start = (state == ST_MUL);
    wval = (state == ST_CLEAR) ? 16'd0 : g_res;
    bf_we = (state == ST_CLEAR && clr_addr < CTX_AW'(BF_DEPTH)) ||
            (state == ST_DIV && g_done && tsel == 2'd0);
    cm_we = (state == ST_CLEAR) || (state == ST_DIV && g_done && tsel == 2'd1);
    fu_we = (state == ST_CLEAR) || (state == ST_DIV && g_done && tsel == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      ctx_en <= 1'b1;
      skip <= 1'b0;
      tsel <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) ctx_en <= cfg.data;
      if (state == ST_CLEAR) clr_addr <= clr_addr + CTX_AW'(1);
      if (state == ST_IDLE && in.valid) begin
        cur <= in.data;
        tsel <= '0;
        acc <= '0;
        if (in.data.action == ACT_CLEAR) begin
          clr_addr <= '0;
          skip <= 1'b0;
        end
        if (in.data.action == ACT_CAPTURE) skip <= 1'b1;
        if (in.data.action == ACT_QUIET) skip <= 1'b0;
      end
      if (state == ST_READ && rd_wait) begin
        if (cur.action == ACT_QUERY && tbl_on(tsel, ctx_en, lp_ok, ep_ok))
          acc <= acc + 18'(g_in);
        if (state_next == ST_READ) tsel <= tsel + 2'd1;
      end
      if (state == ST_DIV && g_done && tsel != 2'd2) tsel <= tsel + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      if (clr_addr < CTX_AW'(PLY_LIMIT)) begin
        k0[clr_addr[PLY_AW-1:0]] <= '0;
        k1[clr_addr[PLY_AW-1:0]] <= '0;
      end
      if (clr_addr < CTX_AW'(REPLY_DEPTH)) reply[clr_addr[REPLY_AW-1:0]] <= '0;
    end else if (state == ST_WRITE && cur.action == ACT_QUIET &&
                 !(ply_ok && (k0_q == cur.move_code || k1_q == cur.move_code))) begin
      if (ply_ok) begin
        k0[ply_i] <= cur.move_code;
        if (k0_q != '0) k1[ply_i] <= k0_q;
      end
      if (lp_ok) reply[rp_a] <= cur.move_code;
    end
    k0_q <= k0[ply_i];
    k1_q <= k1[ply_i];
    rp_q <= reply[rp_a];
  end

  always_comb begin
    res_word.combined_score = (acc > 18'sd32767) ? 16'sh7fff :
                              (acc < -18'sd32768) ? 16'sh8000 : acc[15:0];
    res_word.killer_first = ply_ok ? k0_q : '0;
    res_word.killer_second = ply_ok ? k1_q : '0;
    res_word.counter_move = lp_ok ? rp_q : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (out_load) out_vld <= 1'b1;
    else if (out.ready) out_vld <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out.data <= res_word;
  end

  assert property (@(posedge clk) disable iff (rst) (out.valid && !out.ready) |=> out.valid)
    else $error("result dropped before it was taken");
  assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> $stable(out.data))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst) (bf_we && state != ST_CLEAR) |-> tsel == 2'd0)
    else $error("butterfly write from wrong table step");
  assert property (@(posedge clk) disable iff (rst) in.ready |-> state == ST_IDLE)
    else $error("input taken while busy");
endmodule

// File: rtl/core/hhte_score_ram.sv
module hhte_score_ram #(
  parameter int DEPTH = 8192,
  parameter int AW = 13
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0] rdata
);
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/hhte_gravity.sv
module hhte_gravity (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [15:0] score,
  input  logic [6:0] depth,
  input  logic reward,
  output logic done,
  output logic signed [15:0] result
);
  import hhte_pkg::*;

  // Decay is |b*s| / 32767, taken as (x + (x >> 15) + 1) >> 15, which is exact for x
  // below 2**30.
  logic [13:0] b;
  logic neg;
  logic signed [15:0] s_hold;
  logic [15:0] mag;
  logic [29:0] prod;
  logic [29:0] quo_sum;
  logic [15:0] quo;
  logic [1:0] stage;
  logic signed [15:0] decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= (stage == 2'd2);
      if (start) stage <= 2'd1;
      else if (stage != 2'd0) stage <= (stage == 2'd1) ? 2'd2 : 2'd0;
    end
  end

  assign mag = s_hold[15] ? 16'(-s_hold) : 16'(s_hold);
  assign quo_sum = prod + {15'd0, prod[29:15]} + 30'd1;

  always_ff @(posedge clk) begin
    if (start) begin
      b <= 14'(depth) * 14'(depth);
      neg <= score[15];
      s_hold <= score;
    end
    if (stage == 2'd1) prod <= 30'(b) * 30'(mag);
    if (stage == 2'd2) quo <= {1'b0, quo_sum[29:15]};
  end

  assign decay = neg ? -$signed(quo) : $signed(quo);
  assign result = grav_sat(s_hold, b, decay, reward);
endmodule

// File: dv/tb_history_heuristic_table_engine_top.sv
module tb_history_heuristic_table_engine_top;
  import hhte_pkg::*;

  localparam int PLY_MAX = PLY_LIMIT_DEF;
  localparam int IDLE_LIMIT = 1200000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS = 310;
  localparam int PHASES = 5;

  logic clk;
  logic rst;

  hhte_in_if in_ch();
  hhte_out_if out_ch();
  hhte_cfg_if cfg_ch();

  history_heuristic_table_engine_top #(.PLY_LIMIT(PLY_MAX)) u_top (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch),
    .cfg(cfg_ch)
  );

  typedef struct {
    in_word_t w;
    bit typed;
    out_word_t r;
  } stim_row_t;

  logic tables_on;
  logic signed [15:0] bf_score[int];
  logic signed [15:0] cm_score[int];
  logic signed [15:0] fu_score[int];
  logic [31:0] killer[0:PLY_MAX-1][0:1];
  logic [31:0] reply[int];
  bit skip_pen;

  out_word_t expected_words[$];
  int failures;
  int idle_cycles;
  bit no_stall;

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = 1'b1;
      #10 clk = 1'b0;
    end
  end

  function automatic logic signed [15:0] sc_get(ref logic signed [15:0] t[int], input int k);
    return t.exists(k) ? t[k] : 16'sd0;
  endfunction

  function automatic logic signed [15:0] gravity_step(input logic signed [15:0] s,
                                                     input int d, input bit reward);
    int b;
    int decay;
    int nv;
    b = d * d;
    decay = (b * int'(s)) / 32767;
    nv = int'(s) + (reward ? b : -b) - decay;
    if (nv > 32767) nv = 32767;
    if (nv < -32768) nv = -32768;
    return nv[15:0];
  endfunction

  function automatic int ctx_key(in_word_t w, logic [2:0] pp, logic [5:0] pt);
    logic [2:0] pk;
    pk = (w.piece_kind > 3'd5) ? 3'd5 : w.piece_kind;
    return int'({w.side, pp, pt, pk, w.to_square});
  endfunction

  function automatic void rescore(in_word_t w, bit reward);
    int d;
    int k;
    d = int'(w.search_depth);
    if (d <= 2) return;
    k = int'({w.side, w.from_square, w.to_square});
    bf_score[k] = gravity_step(sc_get(bf_score, k), d, reward);
    if (tables_on) begin
      if (w.last_piece < NO_PIECE) begin
        k = ctx_key(w, w.last_piece, w.last_to);
        cm_score[k] = gravity_step(sc_get(cm_score, k), d, reward);
      end
      if (w.earlier_piece < NO_PIECE) begin
        k = ctx_key(w, w.earlier_piece, w.earlier_to);
        fu_score[k] = gravity_step(sc_get(fu_score, k), d, reward);
      end
    end
  endfunction

  function automatic void wipe_tables();
    bf_score.delete();
    cm_score.delete();
    fu_score.delete();
    reply.delete();
    for (int i = 0; i < PLY_MAX; i++) begin
      killer[i][0] = '0;
      killer[i][1] = '0;
    end
    skip_pen = 1'b0;
  endfunction

  function automatic bit table_step(in_word_t w, output out_word_t r);
    int h;
    int rk;
    int ply;
    r = '0;
    ply = int'(w.search_ply);
    rk = int'({~w.side, w.last_piece, w.last_to});
    case (w.action)
      ACT_CLEAR: wipe_tables();
      ACT_QUIET: begin
        skip_pen = 1'b0;
        rescore(w, 1'b1);
        if (ply < PLY_MAX) begin
          if (killer[ply][0] == w.move_code || killer[ply][1] == w.move_code) return 1'b0;
          if (killer[ply][0] != '0) killer[ply][1] = killer[ply][0];
          killer[ply][0] = w.move_code;
        end
        if (w.last_piece < NO_PIECE) reply[rk] = w.move_code;
      end
      ACT_CAPTURE: skip_pen = 1'b1;
      ACT_PENALTY: if (!skip_pen) rescore(w, 1'b0);
      ACT_QUERY: begin
        h = int'(sc_get(bf_score, int'({w.side, w.from_square, w.to_square})));
        if (tables_on) begin
          if (w.last_piece < NO_PIECE)
            h += int'(sc_get(cm_score, ctx_key(w, w.last_piece, w.last_to)));
          if (w.earlier_piece < NO_PIECE)
            h += int'(sc_get(fu_score, ctx_key(w, w.earlier_piece, w.earlier_to)));
        end
        if (h > 32767) h = 32767;
        if (h < -32768) h = -32768;
        r.combined_score = h[15:0];
        r.killer_first = (ply < PLY_MAX) ? killer[ply][0] : '0;
        r.killer_second = (ply < PLY_MAX) ? killer[ply][1] : '0;
        r.counter_move = (w.last_piece < NO_PIECE && reply.exists(rk)) ? reply[rk] : '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_r);
    out_word_t r;
    while (!no_stall && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (table_step(w, r)) expected_words.push_back(typed ? typed_r : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tables_on = v;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_move();
    logic [31:0] pool[6] = '{32'd0, 32'hffffffff, 32'h1, 32'h8000_0000, 32'h1234, 32'h55aa};
    if ($urandom_range(0, 3) == 0) return $urandom();
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [5:0] pick_square();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(61, 63));
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int a;
    a = $urandom_range(0, 99);
    if (a < 35) w.action = ACT_QUIET;
    else if (a < 65) w.action = ACT_PENALTY;
    else if (a < 93) w.action = ACT_QUERY;
    else if (a < 98) w.action = ACT_CAPTURE;
    else w.action = 3'($urandom_range(5, 7));
    w.move_code = pick_move();
    w.side = 1'($urandom_range(0, 1));
    w.piece_kind = 3'($urandom_range(0, 7));
    w.from_square = pick_square();
    w.to_square = pick_square();
    w.search_depth = $urandom_range(0, 4) == 0 ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(2, 24));
    w.search_ply = $urandom_range(0, 4) == 0 ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 3));
    w.last_piece = 3'($urandom_range(0, 7));
    w.last_to = pick_square();
    w.earlier_piece = 3'($urandom_range(0, 7));
    w.earlier_to = pick_square();
    return w;
  endfunction

  function automatic in_word_t mk(action_t a, logic [31:0] mv, logic sd, logic [2:0] pk,
                                  logic [5:0] fr, logic [5:0] to, logic [6:0] d,
                                  logic [6:0] ply, logic [2:0] lp, logic [5:0] lt,
                                  logic [2:0] ep, logic [5:0] et);
    in_word_t w;
    w = '{a, mv, sd, pk, fr, to, d, ply, lp, lt, ep, et};
    return w;
  endfunction

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_ch.data.combined_score !== e.combined_score) begin
          $error("combined_score expected %0d actual %0d", e.combined_score,
                 out_ch.data.combined_score);
          failures++;
        end
        if (out_ch.data.killer_first !== e.killer_first) begin
          $error("killer_first expected %h actual %h", e.killer_first,
                 out_ch.data.killer_first);
          failures++;
        end
        if (out_ch.data.killer_second !== e.killer_second) begin
          $error("killer_second expected %h actual %h", e.killer_second,
                 out_ch.data.killer_second);
          failures++;
        end
        if (out_ch.data.counter_move !== e.counter_move) begin
          $error("counter_move expected %h actual %h", e.counter_move,
                 out_ch.data.counter_move);
          failures++;
        end
      end
    end
    out_ch.ready <= no_stall || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("history_heuristic_table_engine_top test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    out_word_t zero_r;
    out_word_t tr;
    logic cfg_plan[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    failures = 0;
    idle_cycles = 0;
    no_stall = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    tables_on = 1'b1;
    wipe_tables();
    zero_r = '0;
    tr = '0;
    tr.killer_first = 32'hA5;
    tr.counter_move = 32'hA5;

    rows.push_back('{mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_r});
    rows.push_back('{mk(ACT_QUERY, '1, 1, 7, 63, 63, 127, 127, 7, 63, 7, 63), 1, zero_r});
    rows.push_back('{mk(ACT_QUIET, 32'hA5, 0, 0, 1, 2, 2, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(ACT_QUERY, 0, 0, 0, 1, 2, 0, 0, 0, 5, 6, 0), 1, tr});
    rows.push_back('{mk(ACT_QUIET, 32'hA5, 0, 0, 1, 2, 5, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(ACT_QUIET, 0, 1, 3, 4, 5, 9, 1, 2, 7, 6, 0), 0, zero_r});
    rows.push_back('{mk(ACT_QUIET, 32'h77, 1, 7, 63, 63, 127, 70, 6, 0, 7, 0), 0, zero_r});
    rows.push_back('{mk(ACT_QUERY, 0, 1, 7, 63, 63, 0, 70, 5, 0, 5, 0), 0, zero_r});
    rows.push_back('{mk(ACT_QUIET, 32'h99, 0, 5, 1, 2, 127, 0, 5, 63, 5, 63), 0, zero_r});
    rows.push_back('{mk(ACT_CAPTURE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_r});
    rows.push_back('{mk(ACT_PENALTY, 0, 0, 0, 1, 2, 127, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(ACT_QUERY, 0, 0, 6, 1, 2, 0, 0, 5, 63, 5, 63), 0, zero_r});
    rows.push_back('{mk(ACT_QUIET, 32'h1, 1, 2, 0, 63, 3, 2, 1, 1, 1, 1), 0, zero_r});
    rows.push_back('{mk(ACT_PENALTY, 0, 1, 2, 0, 63, 127, 0, 1, 1, 1, 1), 0, zero_r});
    rows.push_back('{mk(ACT_PENALTY, 0, 1, 2, 0, 63, 127, 0, 6, 1, 7, 1), 0, zero_r});
    rows.push_back('{mk(action_t'(3'd5), 1, 0, 0, 1, 2, 9, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(action_t'(3'd6), 1, 0, 0, 1, 2, 9, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(action_t'(3'd7), 1, 0, 0, 1, 2, 9, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(ACT_QUERY, 0, 1, 2, 0, 63, 0, 2, 1, 1, 1, 1), 0, zero_r});
    rows.push_back('{mk(ACT_QUERY, 0, 0, 0, 1, 2, 0, 0, 0, 5, 0, 5), 0, zero_r});
    rows.push_back('{mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_r});
    rows.push_back('{mk(ACT_QUERY, 0, 0, 0, 1, 2, 0, 0, 0, 5, 0, 5), 1, zero_r});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_enable(cfg_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_stall = (p == 2);
        if (p == 3 && n == 100) begin
          in_ch.valid <= 1'b0;
          while (expected_words.size() != 0) @(posedge clk);
        end
        send_word(rand_word(), 1'b0, zero_r);
      end
      no_stall = 1'b0;
      drain();
    end

    if (failures == 0 && expected_words.size() == 0) begin
      $display("history_heuristic_table_engine_top test passed");
    end else begin
      $display("history_heuristic_table_engine_top test failed");
    end
    $finish;
  end
endmodule
